### design/hqr_pkg.sv
// Shared types, widths and helpers for the 4x4 Householder QR block.
package hqr_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 4;

    // Multiplier operand and product widths, derivation value widths.
    localparam int MW = 36;
    localparam int PW = 2 * MW;
    localparam int DW = MW;

    typedef struct packed {
        logic signed [31:0] a_c0;
        logic signed [31:0] a_c1;
        logic signed [31:0] a_c2;
        logic signed [31:0] a_c3;
    } in_word_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] q_c0;
        logic signed [31:0] q_c1;
        logic signed [31:0] q_c2;
        logic signed [31:0] q_c3;
        logic signed [31:0] r_c0;
        logic signed [31:0] r_c1;
        logic signed [31:0] r_c2;
        logic signed [31:0] r_c3;
        logic               last_row;
    } out_word_t;

    // Row word as queued between front and back.
    typedef struct packed {
        in_word_t   data;
        logic [1:0] row;
        logic       last;
    } row_word_t;

    typedef enum logic {
        ITER_SQRT = 1'b0,
        ITER_DIV  = 1'b1
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_ctl_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] x);
        logic fits;
        begin
            fits = (&x[PW-1:31]) || !(|x[PW-1:31]);
            if (fits)
                return x[31:0];
            else if (x[PW-1])
                return 32'sh80000000;
            else
                return 32'sh7fffffff;
        end
    endfunction

endpackage

### design/householder_qr_4x4.sv
// The first result word follows the fourth row word once the computation is through, which
// includes the normalizing shifts of the reflection vector and is set by the shared multiplier
// and the 32-step square root and (FRAC_BITS+2)-step divider run in turn.
// The back end computes one matrix (four row words in, four result words out) at a time.
// The row queue takes up to FIFO_DEPTH rows of the next matrix while one is computed.
// Reset (rst_n low, asynchronous) empties the queue, clears the row count and idles the block.
module householder_qr_4x4 import hqr_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      a_valid,
    output logic      a_stall,
    input  in_word_t  a_row,
    output logic      qr_valid,
    input  logic      qr_stall,
    output out_word_t qr_row
);

    // Front end tags rows; the queue decouples it from the compute sequencer.
    logic      fifo_push;
    row_word_t fifo_in;
    logic      fifo_full;
    logic      fifo_pop;
    logic      fifo_valid;
    row_word_t fifo_out;

    hqr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_valid   (a_valid),
        .a_stall   (a_stall),
        .a_row     (a_row),
        .fifo_full (fifo_full),
        .push      (fifo_push),
        .push_word (fifo_in)
    );

    hqr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_word (fifo_in),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .valid     (fifo_valid),
        .pop_word  (fifo_out)
    );

    // Back end: loads the matrix, runs three reflections, then emits Q and R rows.
    hqr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (fifo_valid),
        .fifo_word  (fifo_out),
        .fifo_pop   (fifo_pop),
        .qr_valid   (qr_valid),
        .qr_stall   (qr_stall),
        .qr_row     (qr_row)
    );

    // Back end never pops an empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> fifo_valid)
        else $error("row queue popped while empty");

    // Last marker goes with row three only.
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        qr_valid |-> (qr_row.last_row == (qr_row.row_index == 2'd3)))
        else $error("last_row does not match row_index");

    // After the final row of a matrix leaves, the next result needs a full computation.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (qr_valid && !qr_stall && qr_row.last_row) |=> !qr_valid)
        else $error("result word right after last row");

endmodule

### design/hqr_front.sv
// Front end: accepts A rows and tags each with its row number.
module hqr_front import hqr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      a_valid,
    output logic      a_stall,
    input  in_word_t  a_row,
    input  logic      fifo_full,
    output logic      push,
    output row_word_t push_word
);

    logic [1:0] rows_reg;
    logic [1:0] rows_next;

    always_comb
    begin
        a_stall        = fifo_full;
        push           = a_valid && !fifo_full;
        push_word.data = a_row;
        push_word.row  = rows_reg;
        push_word.last = (rows_reg == 2'd3);
        rows_next      = push ? rows_reg + 2'd1 : rows_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows_reg <= 2'd0;
        else
            rows_reg <= rows_next;
    end

endmodule

### design/hqr_fifo.sv
// Short row queue between front end and back end.
module hqr_fifo import hqr_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  row_word_t push_word,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output row_word_t pop_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    row_word_t         mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, wr_next;
    logic [AW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    always_comb
    begin
        full     = (cnt_reg == CW'(DEPTH));
        valid    = (cnt_reg != '0);
        pop_word = mem_reg[rd_reg];
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        if (pop)
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_word;
    end

endmodule

### design/hqr_iter.sv
// Shared iterative unit: 64-bit floor square root or restoring divide.
module hqr_iter import hqr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int NUMW = 32 + FRAC_BITS,
    localparam int QW   = FRAC_BITS + 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  iter_ctl_t       ctl,
    input  logic [63:0]     radicand,
    input  logic [NUMW-1:0] numer,
    input  logic [31:0]     denom,
    output logic            done,
    output logic [31:0]     root,
    output logic [QW-1:0]   quot
);

    iter_op_t        op_reg, op_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [63:0]     x_reg, x_next;
    logic [63:0]     res_reg, res_next;
    logic [63:0]     bit_reg, bit_next;
    logic [32:0]     rem_reg, rem_next;
    logic [QW-1:0]   low_reg, low_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [31:0]     den_reg, den_next;
    logic [63:0]     rb;
    logic [32:0]     tdiv;

    assign done = done_reg;
    assign root = res_reg[31:0];
    assign quot = q_reg;

    always_comb
    begin
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        rb        = res_reg + bit_reg;
        tdiv      = {rem_reg[31:0], low_reg[QW-1]};
        if (ctl.start)
        begin
            op_next   = ctl.op;
            cnt_next  = (ctl.op == ITER_SQRT) ? 6'd32 : 6'(QW);
            busy_next = 1'b1;
            x_next    = radicand;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            rem_next  = 33'(numer >> QW);
            low_next  = numer[QW-1:0];
            q_next    = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            if (op_reg == ITER_SQRT)
            begin
                if (x_reg >= rb)
                begin
                    x_next   = x_reg - rb;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
            end
            else
            begin
                if (tdiv >= {1'b0, den_reg})
                begin
                    rem_next = tdiv - {1'b0, den_reg};
                    q_next   = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = tdiv;
                    q_next   = {q_reg[QW-2:0], 1'b0};
                end
                low_next = low_reg << 1;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

endmodule

### design/hqr_back.sv
// Back end: sequencer with one shared multiplier that runs the QR reduction.
module hqr_back import hqr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fifo_valid,
    input  row_word_t fifo_word,
    output logic      fifo_pop,
    output logic      qr_valid,
    input  logic      qr_stall,
    output out_word_t qr_row
);

    localparam int NUMW = 32 + FRAC_BITS;
    localparam int QW   = FRAC_BITS + 2;
    localparam int UW   = FRAC_BITS + 2;
    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [16:0] {
        S_LOAD      = 17'b00000000000000001,
        S_SQ_MUL    = 17'b00000000000000010,
        S_SQ_ACC    = 17'b00000000000000100,
        S_ROOT_GO   = 17'b00000000000001000,
        S_ROOT_WAIT = 17'b00000000000010000,
        S_NORM      = 17'b00000000000100000,
        S_NSQ_MUL   = 17'b00000000001000000,
        S_NSQ_ACC   = 17'b00000000010000000,
        S_DIV_GO    = 17'b00000000100000000,
        S_DIV_WAIT  = 17'b00000001000000000,
        S_RD_MUL    = 17'b00000010000000000,
        S_RD_ACC    = 17'b00000100000000000,
        S_RU_MUL    = 17'b00001000000000000,
        S_RU_ACC    = 17'b00010000000000000,
        S_OR_MUL    = 17'b00100000000000000,
        S_OR_ACC    = 17'b01000000000000000,
        S_OUT       = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic [1:0] r_reg, r_next;
    logic       xsel_reg, xsel_next;
    logic       pass_reg, pass_next;
    logic       out_valid_reg, out_valid_next;

    logic signed [31:0]   a_reg [16];
    logic signed [31:0]   a_next [16];
    logic signed [31:0]   w_reg [16];
    logic signed [31:0]   w_next [16];
    logic signed [31:0]   p_reg [16];
    logic signed [31:0]   p_next [16];
    logic signed [UW-1:0] u_reg [4];
    logic signed [UW-1:0] u_next [4];
    logic [33:0]          vm_reg [4];
    logic [33:0]          vm_next [4];
    logic                 vneg_reg [4];
    logic                 vneg_next [4];
    logic signed [31:0]   qb_reg [4];
    logic signed [31:0]   qb_next [4];
    logic signed [31:0]   rb_reg [4];
    logic signed [31:0]   rb_next [4];
    logic [63:0]          sum_reg, sum_next;
    logic [31:0]          n_reg, n_next;
    logic signed [DW-1:0] d_reg, d_next;
    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] mul_reg;
    out_word_t            out_reg, out_next;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [31:0]   row_vals [4];
    logic signed [31:0]   w_col;
    logic [32:0]          w_mag;
    logic signed [31:0]   x_rd;
    logic signed [31:0]   x_new;
    logic signed [PW-1:0] rnd_prod, rnd_dbl;
    logic [64:0]          sum_add;
    logic [63:0]          sum_sat;
    logic [33:0]          vm_m01, vm_m23, vm_max;
    logic signed [UW-1:0] q_s;
    logic signed [PW-1:0] acc_sum;
    iter_ctl_t            it_ctl;
    logic [63:0]          it_rad;
    logic [NUMW-1:0]      it_num;
    logic                 it_done;
    logic [31:0]          it_root;
    logic [QW-1:0]        it_quot;

    // Round off FRAC_BITS, half away from zero.
    function automatic logic signed [PW-1:0] rnd_f(input logic signed [PW-1:0] x);
        logic [PW-1:0] m;
        logic [PW-1:0] r;
        begin
            m = x[PW-1] ? PW'(-x) : PW'(x);
            r = (m + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            return x[PW-1] ? -$signed(r) : $signed(r);
        end
    endfunction

    hqr_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (it_ctl),
        .radicand (it_rad),
        .numer    (it_num),
        .denom    (n_reg),
        .done     (it_done),
        .root     (it_root),
        .quot     (it_quot)
    );

    assign qr_valid = out_valid_reg;
    assign qr_row   = out_reg;

    always_comb
    begin
        row_vals[0] = fifo_word.data.a_c0;
        row_vals[1] = fifo_word.data.a_c1;
        row_vals[2] = fifo_word.data.a_c2;
        row_vals[3] = fifo_word.data.a_c3;
        w_col    = w_reg[{i_reg, k_reg}];
        w_mag    = w_col[31] ? 33'(-34'(w_col)) : 33'(w_col);
        x_rd     = xsel_reg ? p_reg[{i_reg, j_reg}] : w_reg[{i_reg, j_reg}];
        rnd_prod = rnd_f(mul_reg);
        rnd_dbl  = rnd_f(mul_reg <<< 1);
        x_new    = sat32(PW'(x_rd) - rnd_dbl);
        acc_sum  = acc_reg + rnd_prod;
        sum_add  = {1'b0, sum_reg} + {1'b0, mul_reg[63:0]};
        sum_sat  = sum_add[64] ? '1 : sum_add[63:0];
        vm_m01   = (vm_reg[0] > vm_reg[1]) ? vm_reg[0] : vm_reg[1];
        vm_m23   = (vm_reg[2] > vm_reg[3]) ? vm_reg[2] : vm_reg[3];
        vm_max   = (vm_m01 > vm_m23) ? vm_m01 : vm_m23;
        q_s      = $signed(it_quot);
        it_rad   = sum_reg;
        it_num   = (NUMW'(vm_reg[i_reg][30:0]) << FRAC_BITS) + NUMW'(n_reg[31:1]);
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        r_next         = r_reg;
        xsel_next      = xsel_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        a_next         = a_reg;
        w_next         = w_reg;
        p_next         = p_reg;
        u_next         = u_reg;
        vm_next        = vm_reg;
        vneg_next      = vneg_reg;
        qb_next        = qb_reg;
        rb_next        = rb_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        fifo_pop       = 1'b0;
        it_ctl.start   = 1'b0;
        it_ctl.op      = ITER_SQRT;
        mul_a          = '0;
        mul_b          = '0;

        if (out_valid_reg && !qr_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                if (fifo_valid)
                begin
                    fifo_pop = 1'b1;
                    for (int c = 0; c < 4; c++)
                    begin
                        a_next[{fifo_word.row, 2'(c)}] = row_vals[c];
                        w_next[{fifo_word.row, 2'(c)}] = row_vals[c];
                    end
                    if (fifo_word.last)
                    begin
                        for (int n = 0; n < 16; n++)
                            p_next[n] = (n % 5 == 0) ? ONE_FX : 32'sd0;
                        k_next     = 2'd0;
                        i_next     = 2'd0;
                        sum_next   = '0;
                        pass_next  = 1'b0;
                        for (int n = 0; n < 4; n++)
                        begin
                            vm_next[n]   = '0;
                            vneg_next[n] = 1'b0;
                        end
                        state_next = S_SQ_MUL;
                    end
                end
            end
            S_SQ_MUL:
            begin
                mul_a = MW'($signed({1'b0, w_mag}));
                mul_b = MW'($signed({1'b0, w_mag}));
                vm_next[i_reg]   = 34'(w_mag);
                vneg_next[i_reg] = (i_reg == k_reg) ? (w_col <= 32'sd0) : (w_col < 32'sd0);
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                sum_next = sum_sat;
                if (i_reg == 2'd3)
                    state_next = S_ROOT_GO;
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_ROOT_GO:
            begin
                it_ctl.start = 1'b1;
                it_ctl.op    = ITER_SQRT;
                state_next   = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (it_done)
                begin
                    if (!pass_reg)
                    begin
                        vm_next[k_reg] = vm_reg[k_reg] + 34'(it_root);
                        state_next     = S_NORM;
                    end
                    else
                    begin
                        n_next     = it_root;
                        i_next     = 2'd0;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_NORM:
            begin
                if (vm_max == '0)
                begin
                    // zero column: identity reflection
                    if (k_reg == 2'd2)
                    begin
                        r_next     = 2'd0;
                        j_next     = 2'd0;
                        i_next     = 2'd0;
                        acc_next   = '0;
                        state_next = S_OR_MUL;
                    end
                    else
                    begin
                        k_next    = k_reg + 2'd1;
                        i_next    = k_reg + 2'd1;
                        sum_next  = '0;
                        pass_next = 1'b0;
                        for (int n = 0; n < 4; n++)
                        begin
                            vm_next[n]   = '0;
                            vneg_next[n] = 1'b0;
                        end
                        state_next = S_SQ_MUL;
                    end
                end
                else if (vm_max[33:31] != 3'd0)
                begin
                    for (int n = 0; n < 4; n++)
                        vm_next[n] = vm_reg[n] >> 1;
                end
                else if (!vm_max[30])
                begin
                    for (int n = 0; n < 4; n++)
                        vm_next[n] = vm_reg[n] << 1;
                end
                else
                begin
                    i_next     = 2'd0;
                    sum_next   = '0;
                    state_next = S_NSQ_MUL;
                end
            end
            S_NSQ_MUL:
            begin
                mul_a      = MW'($signed({1'b0, vm_reg[i_reg]}));
                mul_b      = MW'($signed({1'b0, vm_reg[i_reg]}));
                state_next = S_NSQ_ACC;
            end
            S_NSQ_ACC:
            begin
                sum_next = sum_sat;
                if (i_reg == 2'd3)
                begin
                    pass_next  = 1'b1;
                    state_next = S_ROOT_GO;
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_NSQ_MUL;
                end
            end
            S_DIV_GO:
            begin
                it_ctl.start = 1'b1;
                it_ctl.op    = ITER_DIV;
                state_next   = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (it_done)
                begin
                    u_next[i_reg] = vneg_reg[i_reg] ? -q_s : q_s;
                    if (i_reg == 2'd3)
                    begin
                        i_next     = 2'd0;
                        j_next     = 2'd0;
                        xsel_next  = 1'b0;
                        d_next     = '0;
                        state_next = S_RD_MUL;
                    end
                    else
                    begin
                        i_next     = i_reg + 2'd1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_RD_MUL:
            begin
                mul_a      = MW'(u_reg[i_reg]);
                mul_b      = MW'(x_rd);
                state_next = S_RD_ACC;
            end
            S_RD_ACC:
            begin
                d_next = d_reg + DW'(rnd_prod);
                if (i_reg == 2'd3)
                begin
                    i_next     = 2'd0;
                    state_next = S_RU_MUL;
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_RD_MUL;
                end
            end
            S_RU_MUL:
            begin
                mul_a      = MW'(u_reg[i_reg]);
                mul_b      = d_reg;
                state_next = S_RU_ACC;
            end
            S_RU_ACC:
            begin
                if (xsel_reg)
                    p_next[{i_reg, j_reg}] = x_new;
                else
                    w_next[{i_reg, j_reg}] = x_new;
                if (i_reg != 2'd3)
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_RU_MUL;
                end
                else
                begin
                    i_next = 2'd0;
                    d_next = '0;
                    if (j_reg != 2'd3)
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = S_RD_MUL;
                    end
                    else if (!xsel_reg)
                    begin
                        j_next     = 2'd0;
                        xsel_next  = 1'b1;
                        state_next = S_RD_MUL;
                    end
                    else if (k_reg == 2'd2)
                    begin
                        r_next     = 2'd0;
                        j_next     = 2'd0;
                        acc_next   = '0;
                        state_next = S_OR_MUL;
                    end
                    else
                    begin
                        k_next    = k_reg + 2'd1;
                        i_next    = k_reg + 2'd1;
                        sum_next  = '0;
                        pass_next = 1'b0;
                        for (int n = 0; n < 4; n++)
                        begin
                            vm_next[n]   = '0;
                            vneg_next[n] = 1'b0;
                        end
                        state_next = S_SQ_MUL;
                    end
                end
            end
            S_OR_MUL:
            begin
                mul_a      = MW'(p_reg[{r_reg, i_reg}]);
                mul_b      = MW'(a_reg[{i_reg, j_reg}]);
                state_next = S_OR_ACC;
            end
            S_OR_ACC:
            begin
                acc_next       = acc_sum;
                qb_next[j_reg] = p_reg[{j_reg, r_reg}];
                if (i_reg == 2'd3)
                begin
                    rb_next[j_reg] = sat32(acc_sum);
                    acc_next       = '0;
                    i_next         = 2'd0;
                    if (j_reg == 2'd3)
                        state_next = S_OUT;
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = S_OR_MUL;
                    end
                end
                else
                begin
                    i_next     = i_reg + 2'd1;
                    state_next = S_OR_MUL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !qr_stall)
                begin
                    out_next.row_index = r_reg;
                    out_next.q_c0      = qb_reg[0];
                    out_next.q_c1      = qb_reg[1];
                    out_next.q_c2      = qb_reg[2];
                    out_next.q_c3      = qb_reg[3];
                    out_next.r_c0      = rb_reg[0];
                    out_next.r_c1      = rb_reg[1];
                    out_next.r_c2      = rb_reg[2];
                    out_next.r_c3      = rb_reg[3];
                    out_next.last_row  = (r_reg == 2'd3);
                    out_valid_next     = 1'b1;
                    if (r_reg == 2'd3)
                        state_next = S_LOAD;
                    else
                    begin
                        r_next     = r_reg + 2'd1;
                        j_next     = 2'd0;
                        state_next = S_OR_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            k_reg         <= 2'd0;
            i_reg         <= 2'd0;
            j_reg         <= 2'd0;
            r_reg         <= 2'd0;
            xsel_reg      <= 1'b0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            r_reg         <= r_next;
            xsel_reg      <= xsel_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        w_reg    <= w_next;
        p_reg    <= p_next;
        u_reg    <= u_next;
        vm_reg   <= vm_next;
        vneg_reg <= vneg_next;
        qb_reg   <= qb_next;
        rb_reg   <= rb_next;
        sum_reg  <= sum_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
        mul_reg  <= mul_a * mul_b;
    end

endmodule
